[sv/sem_pkg.sv]
`default_nettype none

package sem_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  localparam int CFG_W = 13;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_W-1:0] MIN_SIZE     = 13'd3;
  localparam logic [CFG_W-1:0] MAX_HEIGHT   = 13'd4096;

  // sum of squares of two 10-bit gradient magnitudes
  localparam int SQ_W = 21;

  // above this sum the rounded root is at least 256
  localparam logic [SQ_W-1:0] SAT_LIMIT = 21'd65280;
  localparam logic [7:0]      MAG_MAX   = 8'd255;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } sem_in_t;

  typedef struct packed {
    logic [7:0]  magnitude;
    logic [11:0] out_column;
    logic [11:0] out_row;
    logic        frame_done;
  } sem_out_t;

  // status of the square-root unit toward the sequencer
  typedef struct packed {
    logic       done;
    logic [7:0] root;
  } sem_root_t;

endpackage

`default_nettype wire

[sv/sobel_edge_magnitude.sv]
`default_nettype none

// 3x3 sobel gradient magnitude over an 8-bit grey frame in raster order, one
// pixel per src word. the two rows above the current one live in a single
// line memory (upper and middle row side by side in one 16-bit entry, one
// entry per column), the two previous columns of the neighbourhood in six
// window registers. for every interior pixel a result word carries
// round(sqrt(gx*gx + gy*gy)) saturated at 255, the centre column and row,
// and frame_done on the last interior result of the frame; border pixels
// give no result. a pixel that gives no result occupies the block through
// the accept and the line memory read, when the entry is written back. a
// pixel that completes an interior window occupies it through the accept,
// the memory read, squaring, the bit-serial square-root unit, rounding and
// hand-off, longer if the previous result word still waits in the output
// register. frame_width is clamped to 3..MAX_WIDTH and frame_height to
// 3..4096; frame_start restarts the position counters at column 0, row 0.
// the line memory is not cleared, so the first two rows of a frame after
// reset or after a width increase read stale entries; write the registers
// only while the block is idle.
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             src_valid,
  output logic                  src_ready,
  input  wire sem_in_t          src_word,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output sem_out_t              res_word,
  input  wire logic             cfg_we,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_PUT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [WW-1:0]    fw_ext;
  logic [WW-1:0]    eff_w;
  logic [CFG_W-1:0] eff_h;

  // position and window
  logic [CW-1:0] column_count;
  logic [11:0]   row_count;
  logic [CW-1:0] cur_c;
  logic [11:0]   cur_r;
  logic [7:0]    pix;
  logic [7:0]    win [6];

  // line memory
  logic          src_acc;
  logic          ram_we;
  logic [15:0]   ram_rdata;
  logic [7:0]    up;
  logic [7:0]    mid;

  // datapath
  logic [WW-1:0]    cext;
  logic [CFG_W-1:0] rext;
  logic             emit;
  logic             last_px;
  logic signed [10:0] gx;
  logic signed [10:0] gy;
  logic [9:0]  ax;
  logic [9:0]  ay;
  logic [9:0]  ax_q;
  logic [9:0]  ay_q;
  logic [11:0] hold_col;
  logic [11:0] hold_row;
  logic        hold_done;
  logic [CW-1:0] col_m1;
  logic [SQ_W-1:0] square;
  sem_root_t   sq_stat;

  assign src_ready = (state == ST_IDLE);
  assign src_acc   = src_valid && src_ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the frame size to what the line memory and counters cover
  assign fw_ext = WW'(frame_width);
  always_comb begin
    if (fw_ext < WW'(MIN_SIZE)) begin
      eff_w = WW'(MIN_SIZE);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    if (frame_height < MIN_SIZE) begin
      eff_h = MIN_SIZE;
    end else if (frame_height > MAX_HEIGHT) begin
      eff_h = MAX_HEIGHT;
    end else begin
      eff_h = frame_height;
    end
  end

  // frame_start restarts the position before the memory read goes out
  assign cur_c = src_word.frame_start ? '0 : column_count;
  assign cur_r = src_word.frame_start ? 12'd0 : row_count;

  // entry holds {row r-2, row r-1} of one column
  assign ram_we = (state == ST_READ);

  sem_ram #(
    .WIDTH(16),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (ram_we),
    .waddr(column_count),
    .wdata({mid, pix}),
    .raddr(cur_c),
    .rdata(ram_rdata)
  );

  assign up  = ram_rdata[15:8];
  assign mid = ram_rdata[7:0];

  // window read in the cycle the line memory data returns
  assign cext    = WW'(column_count);
  assign rext    = CFG_W'(row_count);
  assign emit    = (column_count >= CW'(2)) && (row_count >= 12'd2)
                   && (cext < eff_w) && (rext < eff_h);
  assign last_px = (cext == eff_w - WW'(1)) && (rext == eff_h - CFG_W'(1));
  assign col_m1  = column_count - CW'(1);

  // win: 0/1 top row, 2/3 middle row, 4/5 bottom row; even = column c-2
  always_comb begin
    gx = ($signed({3'b000, up}) - $signed({3'b000, win[0]}))
       + (($signed({3'b000, mid}) - $signed({3'b000, win[2]})) <<< 1)
       + ($signed({3'b000, pix}) - $signed({3'b000, win[4]}));
    gy = ($signed({3'b000, win[4]}) + ($signed({3'b000, win[5]}) <<< 1)
          + $signed({3'b000, pix}))
       - ($signed({3'b000, win[0]}) + ($signed({3'b000, win[1]}) <<< 1)
          + $signed({3'b000, up}));
    ax = gx[10] ? 10'(-gx) : 10'(gx);
    ay = gy[10] ? 10'(-gy) : 10'(gy);
  end

  // each product goes straight into the root unit's input register
  assign square = SQ_W'(20'(ax_q) * 20'(ax_q)) + SQ_W'(20'(ay_q) * 20'(ay_q));

  sem_isqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_MUL),
    .square(square),
    .status(sq_stat)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (src_acc) state_next = ST_READ;
      ST_READ: state_next = emit ? ST_MUL : ST_IDLE;
      ST_MUL:  state_next = ST_SQRT;
      ST_SQRT: if (sq_stat.done) state_next = ST_PUT;
      ST_PUT:  if (!res_valid || res_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      row_count    <= 12'd0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= 8'd0;
      end
    end else begin
      state <= state_next;
      if (src_acc) begin
        column_count <= cur_c;
        row_count    <= cur_r;
      end else if (state == ST_READ) begin
        // shift the window one column
        win[0] <= win[1];
        win[1] <= up;
        win[2] <= win[3];
        win[3] <= mid;
        win[4] <= win[5];
        win[5] <= pix;
        // advance raster position, wrapping at the current frame size
        if (cext + WW'(1) >= eff_w) begin
          column_count <= '0;
          row_count    <= (rext + CFG_W'(1) >= eff_h) ? 12'd0 : row_count + 12'd1;
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

  // payload holding registers
  always_ff @(posedge clk) begin
    if (src_acc) begin
      pix <= src_word.pixel;
    end
    if (state == ST_READ) begin
      ax_q      <= ax;
      ay_q      <= ay;
      hold_col  <= 12'(col_m1);
      hold_row  <= row_count - 12'd1;
      hold_done <= last_px;
    end
  end

  // output register parts the result side from the pixel side
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (state == ST_PUT && (!res_valid || res_ready)) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_PUT && (!res_valid || res_ready)) begin
      res_word.magnitude  <= sq_stat.root;
      res_word.out_column <= hold_col;
      res_word.out_row    <= hold_row;
      res_word.frame_done <= hold_done;
    end
  end

`ifndef NO_ASSERTIONS
  // line memory is written back only in the cycle after a pixel is taken
  a_we_after_accept: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(src_acc))
    else $error("line memory write without a preceding accept");

  // the root unit reports only while the sequencer waits for it
  a_done_in_sqrt: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> state == ST_SQRT)
    else $error("root unit done outside the wait state");

  // a new result word appears only from the hand-off state
  a_res_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_PUT))
    else $error("result word raised outside hand-off");

  // interior results never carry the top border row
  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_word.out_row != 12'd0)
    else $error("result on border row");
`endif

endmodule

`default_nettype wire

[sv/sem_ram.sv]
`default_nettype none

module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/sem_isqrt.sv]
`default_nettype none

module sem_isqrt
  import sem_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [SQ_W-1:0] square,
  output sem_root_t            status
);

  logic [15:0] sq;
  logic        sat;
  logic [7:0]  root;
  logic [15:0] rr;
  logic [7:0]  bitm;
  logic        running;
  logic        done;
  logic [7:0]  result;

  logic [7:0]  trial;
  logic [15:0] prod;
  logic [15:0] rem;
  logic        round_up;

  // one trial bit per cycle, msb first
  assign trial    = root | bitm;
  assign prod     = 16'(trial) * 16'(trial);
  assign rem      = sq - rr;
  assign round_up = rem > 16'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running && bitm == 8'd0) begin
      running <= 1'b0;
      done    <= 1'b1;
    end else begin
      done    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sq   <= 16'(square);
      sat  <= square > SAT_LIMIT;
      root <= 8'd0;
      rr   <= 16'd0;
      bitm <= 8'h80;
    end else if (running) begin
      if (bitm != 8'd0) begin
        if (prod <= sq) begin
          root <= trial;
          rr   <= prod;
        end
        bitm <= bitm >> 1;
      end else begin
        if (sat || (round_up && root == MAG_MAX)) begin
          result <= MAG_MAX;
        end else if (round_up) begin
          result <= root + 8'd1;
        end else begin
          result <= root;
        end
      end
    end
  end

  assign status.done = done;
  assign status.root = result;

endmodule

`default_nettype wire
